// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the decimal text formatter RTL.
// Bodies are empty when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define D2DT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define D2DT_NEVER(lbl, clk, rstn, expr, msg) \
    `D2DT_ASSERT(lbl, clk, rstn, !(expr), msg)
`else
`define D2DT_ASSERT(lbl, clk, rstn, prop, msg)
`define D2DT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ----- rtl/d2dt_pkg.sv -----
// Shared types, constants and helper functions of the decimal text formatter.
// No dependencies; used by d2dt_ctrl, d2dt_dp and double_to_decimal_text.
package d2dt_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_CONV,
        ST_LEAD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_INT,
        PH_DOT,
        PH_FRAC
    } phase_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic check;
        logic conv;
        logic lead;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic emit_last;
        logic out_space;
    } status_t;

    localparam int BCD_DIGITS    = 20;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int BITS_PER_STEP = 4;
    localparam int DABBLE_CYCLES = 64 / BITS_PER_STEP;

    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [7:0]  CH_DOT   = 8'h2E;
    localparam logic [3:0]  DIGIT_NINE = 4'd9;
    localparam logic [3:0]  ROUND_MIN  = 4'd5;
    localparam logic [63:0] INT_MAX  = 64'h7fff_ffff_ffff_ffff;

    localparam logic [10:0] EXP_SPECIAL = 11'h7ff;
    // Biased exponents at which the value reaches 2^63 and the binary point.
    localparam logic [11:0] EXP_OVF   = 12'd1086;
    localparam logic [11:0] EXP_POINT = 12'd1011;

    function automatic logic [63:0] pow10_m1(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p - 64'd1;
    endfunction

    // One double-dabble step: adjust every BCD digit, then shift in one bit.
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] b,
                                                     input logic bit_in);
        logic [BCD_W-1:0] t;
        t = b;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (t[4*d +: 4] >= 4'd5) begin
                t[4*d +: 4] = t[4*d +: 4] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], bit_in};
    endfunction

endpackage

// ----- rtl/d2dt_ctrl.sv -----
// Sequencer of the decimal text formatter: one item at a time through
// decode, limit check, digit conversion, lead search and emission. Uses d2dt_pkg.
module d2dt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  d2dt_pkg::status_t  status,
    output d2dt_pkg::cmd_t     cmd
);

    d2dt_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= d2dt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            d2dt_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = d2dt_pkg::ST_DECODE;
            end
            d2dt_pkg::ST_DECODE: state_next = d2dt_pkg::ST_CHECK;
            d2dt_pkg::ST_CHECK:  state_next = d2dt_pkg::ST_CONV;
            d2dt_pkg::ST_CONV: begin
                if (status.conv_done) state_next = d2dt_pkg::ST_LEAD;
            end
            d2dt_pkg::ST_LEAD:   state_next = d2dt_pkg::ST_EMIT;
            d2dt_pkg::ST_EMIT: begin
                if (status.out_space && status.emit_last) state_next = d2dt_pkg::ST_IDLE;
            end
            default: state_next = d2dt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            d2dt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            d2dt_pkg::ST_DECODE: cmd.decode = 1'b1;
            d2dt_pkg::ST_CHECK:  cmd.check  = 1'b1;
            d2dt_pkg::ST_CONV:   cmd.conv   = 1'b1;
            d2dt_pkg::ST_LEAD:   cmd.lead   = 1'b1;
            d2dt_pkg::ST_EMIT:   cmd.emit   = status.out_space;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- rtl/d2dt_dp.sv -----
// Datapath of the decimal text formatter: float decode, fraction digits,
// double-dabble integer digits, rounding and the output register. Uses d2dt_pkg.
`include "assert_macros.svh"
module d2dt_dp #(
    parameter int MAX_FRACTION_DIGITS = 16,
    parameter int INTEGER_DIGITS      = 19
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [63:0]        in_value_bits,
    input  logic [4:0]         in_fraction_digits,
    input  d2dt_pkg::cmd_t     cmd,
    output d2dt_pkg::status_t  status,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [7:0]         m_character,
    output logic               m_last,
    output logic               m_overflow
);

    localparam logic [63:0] POW_LIMIT = d2dt_pkg::pow10_m1(INTEGER_DIGITS);
    localparam logic [63:0] SAT_VALUE =
        (POW_LIMIT < d2dt_pkg::INT_MAX) ? POW_LIMIT : d2dt_pkg::INT_MAX;
    localparam int FD_N = MAX_FRACTION_DIGITS + 1;
    localparam int FDW  = $clog2(FD_N);
    localparam int CONV_CYCLES =
        (FD_N > d2dt_pkg::DABBLE_CYCLES) ? FD_N : d2dt_pkg::DABBLE_CYCLES;
    localparam int CW = $clog2(CONV_CYCLES);

    logic [63:0] bits_reg;
    logic [4:0]  digits_reg;
    logic        sign_reg, ovf_reg, neg_reg, at_limit_reg;
    logic [63:0] ipart_reg, frac_reg, bin_reg, binc_reg;
    logic [d2dt_pkg::BCD_W-1:0] bcd_reg, bcdi_reg;
    logic [CW-1:0] cnt_reg;
    logic [3:0]  fd_reg [FD_N];
    logic        have_k_reg, round_reg, czero_reg, sat9_reg;
    logic [FDW-1:0] k_reg;
    logic [d2dt_pkg::BCD_DIGITS-1:0][3:0] digsel_reg;
    d2dt_pkg::phase_t ph_reg;
    logic [4:0]  eidx_reg;
    logic        m_tvalid_reg, m_last_reg, m_overflow_reg;
    logic [7:0]  m_character_reg;

    // Decode of the binary64 pattern into a Q64.64 magnitude.
    logic [10:0]  ex;
    logic [11:0]  exeff;
    logic [127:0] mant_w, fixed_w;
    logic [11:0]  ramt;
    logic         dec_ovf, dec_nan;

    always_comb begin
        ex      = bits_reg[62:52];
        dec_nan = (ex == d2dt_pkg::EXP_SPECIAL) && (bits_reg[51:0] != 52'd0);
        exeff   = (ex == 11'd0) ? 12'd1 : {1'b0, ex};
        mant_w  = {75'd0, (ex != 11'd0), bits_reg[51:0]};
        ramt    = d2dt_pkg::EXP_POINT - exeff;
        fixed_w = '0;
        dec_ovf = 1'b0;
        if (ex == d2dt_pkg::EXP_SPECIAL || exeff >= d2dt_pkg::EXP_OVF) begin
            dec_ovf = 1'b1;
        end else if (exeff >= d2dt_pkg::EXP_POINT) begin
            fixed_w = mant_w << 7'(exeff - d2dt_pkg::EXP_POINT);
        end else if (ramt < 12'd64) begin
            fixed_w = mant_w >> ramt[5:0];
        end
    end

    logic ovf_chk;
    assign ovf_chk = ovf_reg || (ipart_reg > POW_LIMIT);

    // One fraction digit per cycle: fraction times ten as 8x + 2x.
    logic [67:0] frac_x10;
    logic [3:0]  fdig_new;
    assign frac_x10 = ({4'd0, frac_reg} << 3) + ({4'd0, frac_reg} << 1);
    assign fdig_new = frac_x10[67:64];

    logic [d2dt_pkg::BCD_W-1:0] bcd_step, bcdi_step;
    always_comb begin
        bcd_step  = bcd_reg;
        bcdi_step = bcdi_reg;
        for (int b = 0; b < d2dt_pkg::BITS_PER_STEP; b++) begin
            bcd_step  = d2dt_pkg::dabble_step(bcd_step, bin_reg[63-b]);
            bcdi_step = d2dt_pkg::dabble_step(bcdi_step, binc_reg[63-b]);
        end
    end

    // Lead search picks the rounded integer and its highest nonzero digit.
    logic carry_int, use_inc, sat9;
    logic [d2dt_pkg::BCD_DIGITS-1:0][3:0] sel_bcd;
    logic [4:0] top;
    always_comb begin
        carry_int = round_reg && !have_k_reg;
        sat9      = carry_int && at_limit_reg;
        use_inc   = carry_int && !at_limit_reg;
        sel_bcd   = use_inc ? bcdi_reg : bcd_reg;
        top       = 5'd0;
        for (int i = 0; i < d2dt_pkg::BCD_DIGITS; i++) begin
            if (sel_bcd[i] != 4'd0) top = 5'(i);
        end
    end

    // Character at the current emission position.
    logic [FDW-1:0] fidx;
    logic [3:0]     fd_cur, fd_out;
    logic [7:0]     char_cur;
    logic           last_cur;
    always_comb begin
        fidx   = eidx_reg[FDW-1:0];
        fd_cur = fd_reg[fidx];
        if (sat9_reg) begin
            fd_out = d2dt_pkg::DIGIT_NINE;
        end else if (!round_reg || (!czero_reg && fidx < k_reg)) begin
            fd_out = fd_cur;
        end else if (!czero_reg && fidx == k_reg) begin
            fd_out = fd_cur + 4'd1;
        end else begin
            fd_out = 4'd0;
        end
        char_cur = d2dt_pkg::CH_DOT;
        last_cur = 1'b0;
        case (ph_reg)
            d2dt_pkg::PH_SIGN: char_cur = d2dt_pkg::CH_MINUS;
            d2dt_pkg::PH_INT: begin
                char_cur = d2dt_pkg::CH_ZERO + {4'd0, digsel_reg[eidx_reg]};
                last_cur = (eidx_reg == 5'd0) && (digits_reg == 5'd0);
            end
            d2dt_pkg::PH_DOT: char_cur = d2dt_pkg::CH_DOT;
            d2dt_pkg::PH_FRAC: begin
                char_cur = d2dt_pkg::CH_ZERO + {4'd0, fd_out};
                last_cur = (eidx_reg + 5'd1) == digits_reg;
            end
            default: char_cur = d2dt_pkg::CH_DOT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bits_reg   <= in_value_bits;
            digits_reg <= (8'(in_fraction_digits) > 8'(MAX_FRACTION_DIGITS)) ?
                          5'(MAX_FRACTION_DIGITS) : in_fraction_digits;
        end
        if (cmd.decode) begin
            ovf_reg   <= dec_ovf;
            sign_reg  <= bits_reg[63] && !dec_nan;
            ipart_reg <= fixed_w[127:64];
            frac_reg  <= fixed_w[63:0];
        end
        if (cmd.check) begin
            ovf_reg      <= ovf_chk;
            neg_reg      <= sign_reg && (ovf_chk || ipart_reg != 64'd0 || frac_reg != 64'd0);
            frac_reg     <= ovf_chk ? 64'd0 : frac_reg;
            bin_reg      <= ovf_chk ? SAT_VALUE : ipart_reg;
            binc_reg     <= ipart_reg + 64'd1;
            at_limit_reg <= ipart_reg >= POW_LIMIT;
            bcd_reg      <= '0;
            bcdi_reg     <= '0;
            cnt_reg      <= '0;
            have_k_reg   <= 1'b0;
            round_reg    <= 1'b0;
        end
        if (cmd.conv) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (8'(cnt_reg) < 8'(d2dt_pkg::DABBLE_CYCLES)) begin
                bcd_reg  <= bcd_step;
                bcdi_reg <= bcdi_step;
                bin_reg  <= bin_reg << d2dt_pkg::BITS_PER_STEP;
                binc_reg <= binc_reg << d2dt_pkg::BITS_PER_STEP;
            end
            if (8'(cnt_reg) <= 8'(MAX_FRACTION_DIGITS)) begin
                frac_reg <= frac_x10[63:0];
                fd_reg[cnt_reg[FDW-1:0]] <= fdig_new;
            end
            // Rounding adds one at the last digit that is not a nine.
            if (8'(cnt_reg) < 8'(digits_reg) && fdig_new != d2dt_pkg::DIGIT_NINE) begin
                have_k_reg <= 1'b1;
                k_reg      <= cnt_reg[FDW-1:0];
            end
            if (8'(cnt_reg) == 8'(digits_reg) && digits_reg != 5'd0 &&
                fdig_new >= d2dt_pkg::ROUND_MIN) begin
                round_reg <= 1'b1;
            end
        end
        if (cmd.lead) begin
            czero_reg  <= carry_int;
            digsel_reg <= sel_bcd;
            ovf_reg    <= ovf_reg || sat9;
            ph_reg     <= neg_reg ? d2dt_pkg::PH_SIGN : d2dt_pkg::PH_INT;
            eidx_reg   <= top;
        end
        if (cmd.emit) begin
            m_character_reg <= char_cur;
            m_last_reg      <= last_cur;
            m_overflow_reg  <= ovf_reg;
            case (ph_reg)
                d2dt_pkg::PH_SIGN: ph_reg <= d2dt_pkg::PH_INT;
                d2dt_pkg::PH_INT: begin
                    if (eidx_reg == 5'd0) begin
                        ph_reg <= d2dt_pkg::PH_DOT;
                    end else begin
                        eidx_reg <= eidx_reg - 5'd1;
                    end
                end
                d2dt_pkg::PH_DOT: begin
                    ph_reg   <= d2dt_pkg::PH_FRAC;
                    eidx_reg <= 5'd0;
                end
                d2dt_pkg::PH_FRAC: eidx_reg <= eidx_reg + 5'd1;
                default: ph_reg <= d2dt_pkg::PH_SIGN;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            sat9_reg     <= 1'b0;
        end else begin
            if (cmd.lead) begin
                sat9_reg <= sat9;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;
    assign m_overflow  = m_overflow_reg;

    assign status.conv_done = cnt_reg == CW'(CONV_CYCLES - 1);
    assign status.emit_last = last_cur;
    assign status.out_space = !m_tvalid_reg || m_tready;

    `D2DT_ASSERT(emit_has_room, aclk, aresetn, cmd.emit |-> (!m_tvalid_reg || m_tready), "character emitted over a waiting item")
    `D2DT_ASSERT(char_is_text, aclk, aresetn, m_tvalid_reg |-> (m_character_reg == d2dt_pkg::CH_MINUS || m_character_reg == d2dt_pkg::CH_DOT || (m_character_reg >= d2dt_pkg::CH_ZERO && m_character_reg <= d2dt_pkg::CH_ZERO + 8'd9)), "output is not a text character")
    `D2DT_NEVER(sat_without_ovf, aclk, aresetn, (sat9_reg && $past(cmd.lead) && !ovf_reg), "rounding saturated without overflow flag")

endmodule

// ----- rtl/double_to_decimal_text.sv -----
// Top level of the decimal text formatter: binary64 in, ASCII characters out.
// Instantiates d2dt_ctrl and d2dt_dp; uses d2dt_pkg.
//
//  Channel | Direction | Payload
//  s_      | in        | value_bits, fraction_digits
//  m_      | out       | character, last (tlast), overflow (tuser)
//
// An item passes through decode, limit check, digit conversion and lead search,
// then emits up to 37 characters while the output has room for them.
// The conversion loop converts four integer bits and one fraction digit a cycle;
// emission is set by the single-character output register.
// Reset is synchronous and active low; it clears the sequencer and output valid.
// A stalled output holds emission; the next item is taken once the last
// character sits in the output register.
module double_to_decimal_text #(
    parameter int MAX_FRACTION_DIGITS = 16,
    parameter int INTEGER_DIGITS      = 19
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] value_bits, [68:64] fraction_digits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] character
    output logic        m_tlast,
    output logic        m_tuser    // [0] overflow
);

    d2dt_pkg::cmd_t    cmd;
    d2dt_pkg::status_t status;

    d2dt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    d2dt_dp #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
        .INTEGER_DIGITS      (INTEGER_DIGITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_value_bits      (s_tdata[63:0]),
        .in_fraction_digits (s_tdata[68:64]),
        .cmd                (cmd),
        .status             (status),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .m_character        (m_tdata),
        .m_last             (m_tlast),
        .m_overflow         (m_tuser)
    );

endmodule
